[sv/tun_pkg.sv]
// Shared types and constants for the triangle unit-normal block.
// No dependencies; every file but tun_if refers to this package by scoped names.
package tun_pkg;

    localparam int COORD_BITS_DEF  = 24;
    localparam int NORMAL_BITS_DEF = 16;
    // Degenerate limit: |W|^2 <= 2^-EPS_SQ_SHIFT in real units.
    localparam int EPS_SQ_SHIFT    = 40;

    // Control that travels alongside each request through the pipeline.
    typedef struct packed {
        logic       valid;
        logic       degen;
        logic [2:0] neg;
    } t_ctl;

endpackage

[sv/tun_if.sv]
// Valid/ready channel interfaces for triangle requests and normal results.
// No dependencies.
interface tun_in_if #(parameter int CB = 24);
    logic                 valid;
    logic                 ready;
    logic signed [CB-1:0] ax, ay, az, bx, by, bz, cx, cy, cz;
    modport source (output valid, ax, ay, az, bx, by, bz, cx, cy, cz, input ready);
    modport sink   (input valid, ax, ay, az, bx, by, bz, cx, cy, cz, output ready);
endinterface

interface tun_out_if #(parameter int NB = 16);
    logic                 valid;
    logic                 ready;
    logic signed [NB-1:0] normal_x, normal_y, normal_z;
    logic                 degenerate;
    modport source (output valid, normal_x, normal_y, normal_z, degenerate, input ready);
    modport sink   (input valid, normal_x, normal_y, normal_z, degenerate, output ready);
endinterface

[sv/triangle_unit_normal_unit.sv]
// The front end is six register stages, then one chain cell per result bit,
// then the output register.
// Throughput: one triangle per cycle while the result is not stalled.
// A stalled result freezes the whole pipeline in place, so ready follows it.
// Reset (synchronous, active low) clears only the valid bits; data needs none.
// Top level of the triangle unit-normal block.
// Depends on tun_pkg, tun_if, tun_cross and tun_cell.
module triangle_unit_normal_unit #(
    parameter int COORD_BITS  = tun_pkg::COORD_BITS_DEF,
    parameter int NORMAL_BITS = tun_pkg::NORMAL_BITS_DEF
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    tun_in_if.sink    i_tri,
    tun_out_if.source o_nrm
);
    localparam int C   = COORD_BITS;
    localparam int N   = NORMAL_BITS;
    localparam int MW  = 2*C + 2;
    localparam int SW  = 2*MW + 2*N + 4;
    localparam logic [N-1:0] QMAX = N'((1 << (N-1)) - 1);

    // Advance every stage together whenever the output slot is free or drains.
    logic en;
    logic r_o_valid;
    logic signed [N-1:0] r_nx, r_ny, r_nz;
    logic r_deg;

    assign en          = !r_o_valid || o_nrm.ready;
    assign i_tri.ready = en;

    logic signed [C-1:0] a [3], b [3], c [3];
    assign a[0] = i_tri.ax; assign a[1] = i_tri.ay; assign a[2] = i_tri.az;
    assign b[0] = i_tri.bx; assign b[1] = i_tri.by; assign b[2] = i_tri.bz;
    assign c[0] = i_tri.cx; assign c[1] = i_tri.cy; assign c[2] = i_tri.cz;

    // Chain taps: index N is the front-end output, index 0 the last cell.
    tun_pkg::t_ctl       ctl [N+1];
    logic [SW-1:0]       s   [N+1];
    logic [2:0][SW-1:0]  d   [N+1];
    logic [2:0][SW-1:0]  p   [N+1];
    logic [2:0][N-1:0]   q   [N+1];

    tun_cross #(.C(C), .N(N)) u_cross (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_tri.valid && i_tri.ready),
        .i_a     (a),
        .i_b     (b),
        .i_c     (c),
        .o_ctl   (ctl[N]),
        .o_s     (s[N]),
        .o_r     (d[N])
    );
    assign p[N] = '0;
    assign q[N] = '0;

    // Most significant quotient bit first.
    for (genvar k = N - 1; k >= 0; k--) begin : g_cell
        tun_cell #(.SW(SW), .N(N), .BIT(k)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_ctl   (ctl[k+1]),
            .i_s     (s[k+1]),
            .i_d     (d[k+1]),
            .i_p     (p[k+1]),
            .i_q     (q[k+1]),
            .o_ctl   (ctl[k]),
            .o_s     (s[k]),
            .o_d     (d[k]),
            .o_p     (p[k]),
            .o_q     (q[k])
        );
    end

    // Apply sign, saturate +1.0, zero everything for a degenerate triangle.
    logic [N-1:0] comp [3];
    always_comb begin
        for (int l = 0; l < 3; l++) begin
            if (ctl[0].degen || q[0][l] == '0) begin
                comp[l] = '0;
            end else if (ctl[0].neg[l]) begin
                comp[l] = -q[0][l];
            end else if (q[0][l] > QMAX) begin
                comp[l] = QMAX;
            end else begin
                comp[l] = q[0][l];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (en) begin
            r_o_valid <= ctl[0].valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_nx  <= comp[0];
            r_ny  <= comp[1];
            r_nz  <= comp[2];
            r_deg <= ctl[0].degen;
        end
    end

    assign o_nrm.valid      = r_o_valid;
    assign o_nrm.normal_x   = r_nx;
    assign o_nrm.normal_y   = r_ny;
    assign o_nrm.normal_z   = r_nz;
    assign o_nrm.degenerate = r_deg;

    a_degen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_valid && r_deg |-> r_nx == '0 && r_ny == '0 && r_nz == '0)
        else $error("degenerate result with nonzero normal");

    a_normal_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_valid && !r_deg |-> r_nx != '0 || r_ny != '0 || r_nz != '0)
        else $error("non-degenerate result with zero normal");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_o_valid |-> i_tri.ready)
        else $error("input stalled with empty output slot");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_valid && !o_nrm.ready |=> r_o_valid && $stable(r_nx) && $stable(r_deg))
        else $error("stalled result changed");
endmodule

[sv/tun_cross.sv]
// Front end: edge vectors, cross product, squared components, their sum and the degenerate flag.
// Depends on tun_pkg (t_ctl, EPS_SQ_SHIFT).
module tun_cross #(
    parameter int C = tun_pkg::COORD_BITS_DEF,
    parameter int N = tun_pkg::NORMAL_BITS_DEF,
    localparam int MW  = 2*C + 2,
    localparam int SQW = 2*MW,
    localparam int SUMW = SQW + 2,
    localparam int SW  = SQW + 2*N + 4
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_valid,
    input  logic signed [C-1:0]   i_a [3],
    input  logic signed [C-1:0]   i_b [3],
    input  logic signed [C-1:0]   i_c [3],
    output tun_pkg::t_ctl         o_ctl,
    output logic [SW-1:0]         o_s,
    output logic [2:0][SW-1:0]    o_r
);
    localparam int U    = C + 1;
    localparam int PW   = 2*C + 2;
    localparam int WW   = 2*C + 3;
    localparam int H    = (MW + 1) / 2;
    localparam int HW   = MW - H;
    localparam int FRAC = C / 2;
    localparam bit SMALL = (4*FRAC < tun_pkg::EPS_SQ_SHIFT);
    localparam int LSH  = SMALL ? 0 : 4*FRAC - tun_pkg::EPS_SQ_SHIFT;

    logic [5:0]            r_vld;
    logic signed [U-1:0]   r_u [3], r_v [3];
    logic signed [PW-1:0]  r_p [3], r_q [3];
    logic [MW-1:0]         r_mag [3];
    logic [2:0]            r_neg3, r_neg4, r_neg5, r_neg6;
    logic [2*H-1:0]        r_ll [3];
    logic [MW-1:0]         r_lh [3];
    logic [2*HW-1:0]       r_hh [3];
    logic [SQW-1:0]        r_sq [3];
    logic [SUMW-1:0]       r_sum;
    logic [2:0][SW-1:0]    r_r;
    logic                  r_degen;

    logic signed [WW-1:0]  w [3];
    logic [WW-1:0]         wn [3];
    logic [SUMW-1:0]       sum;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w[i]  = WW'(r_p[i]) - WW'(r_q[i]);
            wn[i] = -w[i];
        end
        sum = SUMW'(r_sq[0]) + SUMW'(r_sq[1]) + SUMW'(r_sq[2]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[4:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r_u[i] <= U'(i_b[i]) - U'(i_a[i]);
                r_v[i] <= U'(i_c[i]) - U'(i_a[i]);
            end
            r_p[0] <= r_u[1] * r_v[2];
            r_q[0] <= r_u[2] * r_v[1];
            r_p[1] <= r_u[2] * r_v[0];
            r_q[1] <= r_u[0] * r_v[2];
            r_p[2] <= r_u[0] * r_v[1];
            r_q[2] <= r_u[1] * r_v[0];
            for (int i = 0; i < 3; i++) begin
                r_neg3[i] <= w[i][WW-1];
                r_mag[i]  <= w[i][WW-1] ? wn[i][MW-1:0] : w[i][MW-1:0];
                // split the square into half-width partial products
                r_ll[i] <= r_mag[i][H-1:0] * r_mag[i][H-1:0];
                r_lh[i] <= r_mag[i][H-1:0] * r_mag[i][MW-1:H];
                r_hh[i] <= r_mag[i][MW-1:H] * r_mag[i][MW-1:H];
                r_sq[i] <= (SQW'(r_hh[i]) << (2*H)) + (SQW'(r_lh[i]) << (H+1))
                         + SQW'(r_ll[i]);
                r_r[i]  <= SW'(r_sq[i]) << (2*(N-1));
            end
            r_neg4  <= r_neg3;
            r_neg5  <= r_neg4;
            r_neg6  <= r_neg5;
            r_sum   <= sum;
            r_degen <= SMALL ? (sum == '0) : (sum <= (SUMW'(1) << LSH));
        end
    end

    assign o_ctl = '{valid: r_vld[5], degen: r_degen, neg: r_neg6};
    assign o_s   = SW'(r_sum);
    assign o_r   = r_r;
endmodule

[sv/tun_cell.sv]
// One bit cell of the normalizing chain: settles bit BIT of each quotient.
// Depends on tun_pkg (t_ctl).
module tun_cell #(
    parameter int SW  = 132,
    parameter int N   = 16,
    parameter int BIT = 0
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  tun_pkg::t_ctl        i_ctl,
    input  logic [SW-1:0]        i_s,
    input  logic [2:0][SW-1:0]   i_d,
    input  logic [2:0][SW-1:0]   i_p,
    input  logic [2:0][N-1:0]    i_q,
    output tun_pkg::t_ctl        o_ctl,
    output logic [SW-1:0]        o_s,
    output logic [2:0][SW-1:0]   o_d,
    output logic [2:0][SW-1:0]   o_p,
    output logic [2:0][N-1:0]    o_q
);
    tun_pkg::t_ctl       r_ctl;
    logic [SW-1:0]       r_s;
    logic [2:0][SW-1:0]  r_d, r_p, n_d, n_p;
    logic [2:0][N-1:0]   r_q, n_q;
    logic [SW-1:0]       term [3];

    // (q + 2^b)^2 S - q^2 S = 2^(b+1) qS + 2^(2b) S; take the bit if it fits in D
    always_comb begin
        for (int l = 0; l < 3; l++) begin
            term[l] = (i_p[l] << (BIT + 1)) + (i_s << (2*BIT));
            if (term[l] <= i_d[l]) begin
                n_d[l] = i_d[l] - term[l];
                n_p[l] = i_p[l] + (i_s << BIT);
                n_q[l] = i_q[l] | (N'(1) << BIT);
            end else begin
                n_d[l] = i_d[l];
                n_p[l] = i_p[l];
                n_q[l] = i_q[l];
            end
        end
    end

    // Clear only the valid bit on reset; the rest of the control just follows.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl.valid <= 1'b0;
        end else if (i_en) begin
            r_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s <= i_s;
            r_d <= n_d;
            r_p <= n_p;
            r_q <= n_q;
        end
    end

    assign o_ctl = r_ctl;
    assign o_s   = r_s;
    assign o_d   = r_d;
    assign o_p   = r_p;
    assign o_q   = r_q;
endmodule

[sim/triangle_unit_normal_unit_test.sv]
// Testbench for the triangle unit-normal block: streams triangles, predicts
// each unit normal with exact wide integer math, and compares every result.
// Depends on tun_pkg, tun_if and triangle_unit_normal_unit.
`timescale 1ns / 1ps

module triangle_unit_normal_unit_test;

    localparam int CB = tun_pkg::COORD_BITS_DEF;
    localparam int NB = tun_pkg::NORMAL_BITS_DEF;
    localparam int CF = CB / 2;
    localparam int LAT = NB + 7;

    typedef struct {
        logic signed [CB-1:0] c[9];
    } tri_t;

    typedef struct {
        logic signed [NB-1:0] nx, ny, nz;
        logic                 degen;
    } nrm_t;

    logic i_clk;
    logic i_rst_n;

    tun_in_if  #(.CB(CB)) tri_ch ();
    tun_out_if #(.NB(NB)) nrm_ch ();

    triangle_unit_normal_unit #(.COORD_BITS(CB), .NORMAL_BITS(NB)) uut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_tri  (tri_ch.sink),
        .o_nrm  (nrm_ch.source)
    );

    tri_t pending_tris[$];
    nrm_t expected_normals[$];
    int   err_count;
    bit   quiet_tail;   // no idling in the last part
    bit   hold_sender;  // pause sender until the result queue drains
    bit   stim_done;

    // ---- prediction ------------------------------------------------------

    // Largest q with q^2 * s <= w^2 * 2^(2*(NB-1)); sign from w, +1.0 saturates.
    function automatic logic signed [NB-1:0] unit_comp(logic signed [127:0] w,
                                                       logic [255:0] s);
        logic [255:0] wm, rhs, q, t;
        wm  = (w < 0) ? -w : w;
        rhs = (wm * wm) << (2 * (NB - 1));
        q   = 0;
        for (int b = NB - 1; b >= 0; b--) begin
            t = q | (256'd1 << b);
            if (t * t * s <= rhs) q = t;
        end
        if (q == 0) return '0;
        if (w < 0) return -q[NB-1:0];
        if (q > (256'd1 << (NB - 1)) - 1) q = (256'd1 << (NB - 1)) - 1;
        return q[NB-1:0];
    endfunction

    function automatic nrm_t predict_normal(tri_t t);
        logic signed [127:0] u[3], v[3], w[3];
        logic [255:0] s;
        nrm_t r;
        for (int i = 0; i < 3; i++) begin
            u[i] = 128'(t.c[3+i]) - 128'(t.c[i]);
            v[i] = 128'(t.c[6+i]) - 128'(t.c[i]);
        end
        w[0] = u[1] * v[2] - u[2] * v[1];
        w[1] = u[2] * v[0] - u[0] * v[2];
        w[2] = u[0] * v[1] - u[1] * v[0];
        s = 0;
        for (int i = 0; i < 3; i++)
            s += 256'(w[i] * w[i]);
        if ((s << tun_pkg::EPS_SQ_SHIFT) <= (256'd1 << (4 * CF))) begin
            r.nx = 0; r.ny = 0; r.nz = 0; r.degen = 1;
        end else begin
            r.nx = unit_comp(w[0], s);
            r.ny = unit_comp(w[1], s);
            r.nz = unit_comp(w[2], s);
            r.degen = 0;
        end
        return r;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0d want %0d", what, got, want);
        err_count++;
    endtask

    // ---- clock, reset, limit --------------------------------------------

    initial begin
        i_clk = 0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #50ms;
        $display("TB_ERROR");
        $finish;
    end

    // ---- driver ---------------------------------------------------------

    int src_idle;
    initial begin
        tri_ch.valid = 0;
        {tri_ch.ax, tri_ch.ay, tri_ch.az, tri_ch.bx, tri_ch.by, tri_ch.bz,
         tri_ch.cx, tri_ch.cy, tri_ch.cz} = '0;
        src_idle = 0;
    end

    always @(posedge i_clk) begin
        tri_t nt;
        if (i_rst_n) begin
            // advance when the current request was taken or none was up
            if (!tri_ch.valid || tri_ch.ready) begin
                if (tri_ch.valid && tri_ch.ready) begin
                    nt.c = '{tri_ch.ax, tri_ch.ay, tri_ch.az, tri_ch.bx, tri_ch.by,
                             tri_ch.bz, tri_ch.cx, tri_ch.cy, tri_ch.cz};
                    expected_normals.insert(expected_normals.size(), predict_normal(nt));
                end
                if (src_idle > 0) begin
                    src_idle <= src_idle - 1;
                    tri_ch.valid <= 0;
                end else if (hold_sender || pending_tris.size() == 0) begin
                    tri_ch.valid <= 0;
                end else if (!quiet_tail && $urandom_range(0, 9) == 0) begin
                    src_idle <= $urandom_range(0, 7);
                    tri_ch.valid <= 0;
                end else begin
                    nt = pending_tris.pop_front();
                    tri_ch.valid <= 1;
                    tri_ch.ax <= nt.c[0]; tri_ch.ay <= nt.c[1]; tri_ch.az <= nt.c[2];
                    tri_ch.bx <= nt.c[3]; tri_ch.by <= nt.c[4]; tri_ch.bz <= nt.c[5];
                    tri_ch.cx <= nt.c[6]; tri_ch.cy <= nt.c[7]; tri_ch.cz <= nt.c[8];
                end
            end
        end
    end

    // ---- monitor --------------------------------------------------------

    int snk_idle;
    initial begin
        nrm_ch.ready = 0;
        snk_idle = 0;
    end

    always @(posedge i_clk) begin
        nrm_t e;
        if (i_rst_n) begin
            if (nrm_ch.valid && nrm_ch.ready) begin
                if (expected_normals.size() == 0) begin
                    report_mismatch("unexpected result", 0, 0);
                end else begin
                    e = expected_normals.pop_front();
                    if (nrm_ch.normal_x !== e.nx)
                        report_mismatch("normal_x", nrm_ch.normal_x, e.nx);
                    if (nrm_ch.normal_y !== e.ny)
                        report_mismatch("normal_y", nrm_ch.normal_y, e.ny);
                    if (nrm_ch.normal_z !== e.nz)
                        report_mismatch("normal_z", nrm_ch.normal_z, e.nz);
                    if (nrm_ch.degenerate !== e.degen)
                        report_mismatch("degenerate", nrm_ch.degenerate, e.degen);
                end
            end
            // stall in random bursts, drop them near the end
            if (snk_idle > 0) begin
                snk_idle <= snk_idle - 1;
                nrm_ch.ready <= 0;
            end else if (!quiet_tail && $urandom_range(0, 9) == 0) begin
                snk_idle <= $urandom_range(0, 7);
                nrm_ch.ready <= 0;
            end else begin
                nrm_ch.ready <= 1;
            end
        end
    end

    // ---- stimulus -------------------------------------------------------

    function automatic logic signed [CB-1:0] rand_coord(int mode);
        case (mode)
            0: return CB'($urandom);
            1: return CB'($urandom_range(0, 64)) - CB'(32);
            2: return $urandom_range(0, 1) ? {1'b0, {(CB-1){1'b1}}} : {1'b1, {(CB-1){1'b0}}};
            default: return CB'($urandom_range(0, 8192)) - CB'(4096);
        endcase
    endfunction

    task automatic add_tri(logic signed [CB-1:0] a0, a1, a2, b0, b1, b2, c0, c1, c2);
        tri_t t;
        t.c = '{a0, a1, a2, b0, b1, b2, c0, c1, c2};
        pending_tris.insert(pending_tris.size(), t);
    endtask

    initial begin
        logic signed [CB-1:0] mx, mn, one, two;
        tri_t t;
        int mode;
        mx = {1'b0, {(CB-1){1'b1}}};
        mn = {1'b1, {(CB-1){1'b0}}};
        one = CB'(1) << CF;
        two = CB'(2) << CF;
        err_count = 0;
        quiet_tail = 0;
        hold_sender = 0;
        stim_done = 0;
        i_rst_n = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1;

        // axis-aligned triangles give exact unit components (+1 saturates, -1 exact)
        add_tri(0, 0, 0, one, 0, 0, 0, one, 0);
        add_tri(0, 0, 0, 0, one, 0, one, 0, 0);
        add_tri(0, 0, 0, 0, one, 0, 0, 0, one);
        add_tri(0, 0, 0, 0, 0, one, 0, one, 0);
        // all points equal: degenerate
        add_tri(5, 5, 5, 5, 5, 5, 5, 5, 5);
        // collinear points
        add_tri(0, 0, 0, one, one, one, two, two, two);
        // tiny cross products around the 2^-20 length limit
        add_tri(0, 0, 0, 1, 0, 0, 0, 1, 0);
        add_tri(0, 0, 0, 16, 0, 0, 0, 16, 0);
        add_tri(0, 0, 0, 32, 0, 0, 0, 32, 0);
        add_tri(0, 0, 0, 32, 0, 0, 0, 33, 0);
        // extremes of the coordinate range
        add_tri(mn, mn, mn, mx, mn, mn, mn, mx, mn);
        add_tri(mx, mx, mx, mn, mx, mx, mx, mn, mx);
        add_tri(mn, mx, mn, mx, mn, mx, mx, mx, mn);
        add_tri(mx, mn, mx, mn, mx, mn, mn, mn, mx);
        add_tri(-1, -1, -1, 0, 0, 0, -1, 0, 1);
        add_tri(mn, 0, mx, 0, mx, mn, mx, mn, 0);

        // pause until every directed result has come
        wait (pending_tris.size() == 0 && !tri_ch.valid);
        hold_sender = 1;
        wait (expected_normals.size() == 0);
        hold_sender = 0;

        for (int n = 0; n < 800; n++) begin
            mode = $urandom_range(0, 3);
            for (int k = 0; k < 9; k++) t.c[k] = rand_coord(mode);
            // some nearly collinear triangles
            if ($urandom_range(0, 9) == 0)
                for (int k = 0; k < 3; k++) t.c[6+k] = t.c[3+k] + CB'($urandom_range(0, 2));
            pending_tris.insert(pending_tris.size(), t);
            if (n == 700) begin
                wait (pending_tris.size() < 10);
                quiet_tail = 1;
            end
        end

        wait (pending_tris.size() == 0 && !tri_ch.valid);
        wait (expected_normals.size() == 0);
        repeat (LAT * 2) @(posedge i_clk);
        if (err_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

[filelist.f]
sv/tun_pkg.sv
sv/tun_if.sv
sv/tun_cross.sv
sv/tun_cell.sv
sv/triangle_unit_normal_unit.sv
sim/triangle_unit_normal_unit_test.sv
